@@ rtl/avlie_pkg.sv @@
// Shared types, constants and helpers of the adaptive variable-length integer encoder.
`timescale 1ns / 1ps

package avlie_pkg;

  // Default width of the value being encoded.
  localparam int DEF_VALUE_WIDTH = 64;

  // Chunk lengths and scores.
  localparam int LEN_W     = 7;
  localparam int MAX_LEN   = 64;
  localparam int THR_W     = 10;
  localparam int SCORE_W   = 12;
  localparam int DELTA_W   = 8;
  localparam int EXT_CNT_W = 6;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Reset values.
  localparam logic [LEN_W-1:0] RST_INITIAL_LEN = 7'd8;
  localparam logic [LEN_W-1:0] RST_EXTEND_LEN  = 7'd4;
  localparam logic [THR_W-1:0] RST_THRESHOLD   = 10'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_INITIAL_LEN = 2'd0,
    CFG_START_EXTEND_LEN  = 2'd1,
    CFG_INITIAL_THRESHOLD = 2'd2,
    CFG_EXTEND_THRESHOLD  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_EMIT,
    ST_ADAPT
  } state_t;

  // Brings a start length into the legal range of 1 to 64.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] res;
    if (v == '0) begin
      res = 7'd1;
    end else if (v > 7'(MAX_LEN)) begin
      res = 7'(MAX_LEN);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

@@ rtl/adaptive_varlen_integer_encoder.sv @@
// Top level of the adaptive variable-length integer encoder.
`timescale 1ns / 1ps

// Each accepted value is cut into chunks, least significant bits first, and one
// output word is produced per chunk: a more_follows flag, the chunk bits (zero
// above chunk_bits) and the chunk length. The first chunk carries the current
// initial length, later chunks the current extension length, and chunks are sent
// until the significant bits of the value (zero counts as one bit) are covered.
// After the last chunk two signed scores adapt both lengths by one step when
// they reach their thresholds. All work runs through one shared right shifter
// under a small sequencer: it takes the value, runs a binary search for the
// bit length, emits one chunk per cycle while the output register is free,
// and then updates the scores. The input is ready only while the sequencer is
// idle; the last chunk of a value sits in the output register and does not
// hold off the next value. A write to a start length register loads that
// length at once and clears its score. Configuration must only be written
// while the encoder is idle.
module adaptive_varlen_integer_encoder #(
  parameter int VALUE_WIDTH = avlie_pkg::DEF_VALUE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_wr_en,
  input  logic [avlie_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [avlie_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [VALUE_WIDTH-1:0]            in_value,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_more_follows,
  output logic [VALUE_WIDTH-1:0]            out_chunk_data,
  output logic [avlie_pkg::LEN_W-1:0]       out_chunk_bits
);

  localparam int LEN_W     = avlie_pkg::LEN_W;
  localparam int SCORE_W   = avlie_pkg::SCORE_W;
  localparam int DELTA_W   = avlie_pkg::DELTA_W;
  localparam int THR_W     = avlie_pkg::THR_W;
  localparam int EXT_CNT_W = avlie_pkg::EXT_CNT_W;
  localparam int SRCH_STEPS = $clog2(VALUE_WIDTH);
  localparam logic [LEN_W-1:0] SH_INIT = LEN_W'(1 << (SRCH_STEPS - 1));
  localparam logic [LEN_W-1:0] VW_LEN  = LEN_W'(VALUE_WIDTH);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(avlie_pkg::MAX_LEN);

  avlie_pkg::state_t state_r, state_nxt;

  // Adaptive state and thresholds.
  logic [LEN_W-1:0]          il_r, il_nxt;
  logic [LEN_W-1:0]          el_r, el_nxt;
  logic signed [SCORE_W-1:0] iscore_r, iscore_nxt;
  logic signed [SCORE_W-1:0] escore_r, escore_nxt;
  logic [THR_W-1:0]          ithr_r, ithr_nxt;
  logic [THR_W-1:0]          ethr_r, ethr_nxt;

  // Per-item working registers.
  logic [VALUE_WIDTH-1:0]    v_r, v_nxt;
  logic [VALUE_WIDTH-1:0]    lv_r, lv_nxt;
  logic [LEN_W-1:0]          sh_r, sh_nxt;
  logic [LEN_W-1:0]          lacc_r, lacc_nxt;
  logic signed [DELTA_W-1:0] rem_r, rem_nxt;
  logic                      first_r, first_nxt;
  logic [EXT_CNT_W-1:0]      ext_cnt_r, ext_cnt_nxt;
  logic [LEN_W-1:0]          pad_r, pad_nxt;

  // Output register.
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_more_r, out_more_nxt;
  logic [VALUE_WIDTH-1:0]    out_data_r, out_data_nxt;
  logic [LEN_W-1:0]          out_bits_r, out_bits_nxt;

  // Shared shifter and helpers.
  logic [VALUE_WIDTH-1:0]    sh_in;
  logic [LEN_W-1:0]          sh_amt;
  logic [VALUE_WIDTH-1:0]    sh_out;
  logic [LEN_W-1:0]          alloc;
  logic [VALUE_WIDTH-1:0]    chunk_mask;
  logic signed [DELTA_W-1:0] alloc_s;
  logic                      more;
  logic                      out_free;
  logic [LEN_W-1:0]          lacc_step;
  logic signed [DELTA_W-1:0] idelta, edelta;
  logic signed [SCORE_W-1:0] isum, esum;
  logic signed [SCORE_W-1:0] ithr_s, ethr_s;

  assign alloc   = first_r ? il_r : el_r;
  assign alloc_s = $signed({1'b0, alloc});

  // The single shifter serves the bit-length search and the chunk stepping.
  always_comb begin
    if (state_r == avlie_pkg::ST_FIND) begin
      sh_in  = lv_r;
      sh_amt = sh_r;
    end else begin
      sh_in  = v_r;
      sh_amt = alloc;
    end
    if (sh_amt >= VW_LEN) begin
      sh_out = '0;
    end else begin
      sh_out = sh_in >> sh_amt;
    end
  end

  // Low bits of the current chunk.
  for (genvar i = 0; i < VALUE_WIDTH; i++) begin : g_mask
    assign chunk_mask[i] = (LEN_W'(i) < alloc);
  end

  assign more     = rem_r > alloc_s;
  assign out_free = !out_valid_r || out_ready;

  // Score deltas of the finished item.
  always_comb begin
    if (ext_cnt_r == '0) begin
      idelta = -$signed({1'b0, pad_r});
      edelta = '0;
    end else begin
      idelta = $signed({{(DELTA_W-EXT_CNT_W){1'b0}}, ext_cnt_r});
      edelta = $signed({{(DELTA_W-EXT_CNT_W){1'b0}}, ext_cnt_r}) - 8'sd1
               - $signed({1'b0, pad_r});
    end
    isum   = iscore_r + SCORE_W'(idelta);
    esum   = escore_r + SCORE_W'(edelta);
    ithr_s = $signed({{(SCORE_W-THR_W){1'b0}}, ithr_r});
    ethr_s = $signed({{(SCORE_W-THR_W){1'b0}}, ethr_r});
  end

  // Sequencer: next state and next values of all registers.
  always_comb begin
    state_nxt     = state_r;
    il_nxt        = il_r;
    el_nxt        = el_r;
    iscore_nxt    = iscore_r;
    escore_nxt    = escore_r;
    ithr_nxt      = ithr_r;
    ethr_nxt      = ethr_r;
    v_nxt         = v_r;
    lv_nxt        = lv_r;
    sh_nxt        = sh_r;
    lacc_nxt      = lacc_r;
    rem_nxt       = rem_r;
    first_nxt     = first_r;
    ext_cnt_nxt   = ext_cnt_r;
    pad_nxt       = pad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_more_nxt  = out_more_r;
    out_data_nxt  = out_data_r;
    out_bits_nxt  = out_bits_r;
    lacc_step     = lacc_r + sh_r;
    in_ready      = 1'b0;

    case (state_r)
      avlie_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          v_nxt       = in_value;
          lv_nxt      = in_value;
          sh_nxt      = SH_INIT;
          lacc_nxt    = '0;
          first_nxt   = 1'b1;
          ext_cnt_nxt = '0;
          state_nxt   = avlie_pkg::ST_FIND;
        end
      end
      avlie_pkg::ST_FIND: begin
        // One halving step of the search for the highest set bit.
        if (sh_out != '0) begin
          lv_nxt   = sh_out;
          lacc_nxt = lacc_step;
        end
        sh_nxt = sh_r >> 1;
        if (sh_r == 7'd1) begin
          rem_nxt   = $signed({1'b0, ((sh_out != '0) ? lacc_step : lacc_r)}) + 8'sd1;
          state_nxt = avlie_pkg::ST_EMIT;
        end
      end
      avlie_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_more_nxt  = more;
          out_data_nxt  = v_r & chunk_mask;
          out_bits_nxt  = alloc;
          v_nxt         = sh_out;
          rem_nxt       = rem_r - alloc_s;
          first_nxt     = 1'b0;
          if (!first_r) begin
            ext_cnt_nxt = ext_cnt_r + 1'b1;
          end
          if (!more) begin
            pad_nxt   = LEN_W'(alloc_s - rem_r);
            state_nxt = avlie_pkg::ST_ADAPT;
          end
        end
      end
      avlie_pkg::ST_ADAPT: begin
        iscore_nxt = isum;
        if (isum >= ithr_s) begin
          if (il_r < MAX_LEN) begin
            il_nxt = il_r + 1'b1;
          end
          iscore_nxt = '0;
        end else if (isum <= -ithr_s) begin
          if (il_r > 7'd1) begin
            il_nxt = il_r - 1'b1;
          end
          iscore_nxt = '0;
        end
        escore_nxt = esum;
        if (esum >= ethr_s) begin
          if (el_r < MAX_LEN) begin
            el_nxt = el_r + 1'b1;
          end
          escore_nxt = '0;
        end else if (esum <= -ethr_s) begin
          if (el_r > 7'd1) begin
            el_nxt = el_r - 1'b1;
          end
          escore_nxt = '0;
        end
        state_nxt = avlie_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = avlie_pkg::ST_IDLE;
      end
    endcase

    // The user must write configuration only while the encoder is idle; the block does not enforce this.
    if (cfg_wr_en) begin
      case (avlie_pkg::cfg_idx_t'(cfg_index))
        avlie_pkg::CFG_START_INITIAL_LEN: begin
          il_nxt     = avlie_pkg::clamp_len(cfg_wr_data[LEN_W-1:0]);
          iscore_nxt = '0;
        end
        avlie_pkg::CFG_START_EXTEND_LEN: begin
          el_nxt     = avlie_pkg::clamp_len(cfg_wr_data[LEN_W-1:0]);
          escore_nxt = '0;
        end
        avlie_pkg::CFG_INITIAL_THRESHOLD: begin
          ithr_nxt = cfg_wr_data[THR_W-1:0];
        end
        avlie_pkg::CFG_EXTEND_THRESHOLD: begin
          ethr_nxt = cfg_wr_data[THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= avlie_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      il_r        <= avlie_pkg::RST_INITIAL_LEN;
      el_r        <= avlie_pkg::RST_EXTEND_LEN;
      iscore_r    <= '0;
      escore_r    <= '0;
      ithr_r      <= avlie_pkg::RST_THRESHOLD;
      ethr_r      <= avlie_pkg::RST_THRESHOLD;
      out_valid_r <= 1'b0;
    end else begin
      il_r        <= il_nxt;
      el_r        <= el_nxt;
      iscore_r    <= iscore_nxt;
      escore_r    <= escore_nxt;
      ithr_r      <= ithr_nxt;
      ethr_r      <= ethr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    lv_r       <= lv_nxt;
    sh_r       <= sh_nxt;
    lacc_r     <= lacc_nxt;
    rem_r      <= rem_nxt;
    first_r    <= first_nxt;
    ext_cnt_r  <= ext_cnt_nxt;
    pad_r      <= pad_nxt;
    out_more_r <= out_more_nxt;
    out_data_r <= out_data_nxt;
    out_bits_r <= out_bits_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_more_follows = out_more_r;
  assign out_chunk_data   = out_data_r;
  assign out_chunk_bits   = out_bits_r;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the adaptive variable-length integer encoder.
`timescale 1ns / 1ps

module testbench;

  localparam int VW           = 64;
  localparam int RESET_CYCLES = 12;
  // Receiver hold-off used to back the encoder up until it refuses input.
  localparam int LONG_HOLD    = 300;
  // Cycles without any accepted word before the run is declared hung. The
  // longest legal quiet stretch is set by the long hold-off.
  localparam int STALL_LIMIT  = 3000;
  // Cycles allowed after the last chunk for the score update to finish.
  localparam int SETTLE       = 10;
  localparam int TAIL         = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_VALUES = 54;

  localparam logic [VW-1:0] CORNERS [12] = '{
    64'h0, 64'h1, 64'h2, 64'hFF, 64'h100, 64'hFFF, 64'h1000,
    64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0123_4567_89AB_CDEF
  };

  // One output word as the encoder should present it.
  typedef struct packed {
    logic          more;
    logic [VW-1:0] data;
    logic [6:0]    bits;
  } chunk_t;

  // Keeps a private copy of the lengths, scores and thresholds, expands every
  // accepted value into its chunks and compares each output word against the
  // oldest chunk still owed.
  class chunk_scoreboard;
    int     init_len, ext_len, init_score, ext_score;
    int     init_thr, ext_thr;
    chunk_t owed_q[$];
    int     errors, values_seen, chunks_seen, longest;

    function new();
      init_len    = int'(avlie_pkg::RST_INITIAL_LEN);
      ext_len     = int'(avlie_pkg::RST_EXTEND_LEN);
      init_thr    = int'(avlie_pkg::RST_THRESHOLD);
      ext_thr     = int'(avlie_pkg::RST_THRESHOLD);
      init_score  = 0;
      ext_score   = 0;
      errors      = 0;
      values_seen = 0;
      chunks_seen = 0;
      longest     = 0;
    endfunction

    function int fit_len(logic [6:0] v);
      if (v == 7'd0) return 1;
      if (v > 7'd64) return 64;
      return int'(v);
    endfunction

    function void set_reg(avlie_pkg::cfg_idx_t idx,
                          logic [avlie_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        avlie_pkg::CFG_START_INITIAL_LEN: begin
          init_len   = fit_len(d[6:0]);
          init_score = 0;
        end
        avlie_pkg::CFG_START_EXTEND_LEN: begin
          ext_len   = fit_len(d[6:0]);
          ext_score = 0;
        end
        avlie_pkg::CFG_INITIAL_THRESHOLD: init_thr = int'(d);
        avlie_pkg::CFG_EXTEND_THRESHOLD:  ext_thr = int'(d);
        default: ;
      endcase
    endfunction

    // One adaptation step: a score that reaches plus or minus its threshold
    // moves its length by one (kept within 1 to 64) and starts over.
    function void move_len(inout int score, inout int len, input int delta, input int thr);
      score += delta;
      if (score >= thr) begin
        if (len < 64) len++;
        score = 0;
      end else if (score <= -thr) begin
        if (len > 1) len--;
        score = 0;
      end
    endfunction

    function void note_value(logic [VW-1:0] v);
      int            sig, left, alloc, e, n, pad, d_init, d_ext, count;
      logic [VW-1:0] rest;
      chunk_t        c;
      sig = 1;
      for (int i = 1; i < VW; i++) if (v[i]) sig = i + 1;
      d_ext = 0;
      if (sig <= init_len) begin
        d_init = sig - init_len;
      end else begin
        e      = sig - init_len;
        n      = (e + ext_len - 1) / ext_len;
        pad    = (ext_len - e % ext_len) % ext_len;
        d_init = n;
        d_ext  = n - 1 - pad;
      end
      rest  = v;
      left  = sig;
      alloc = init_len;
      count = 0;
      do begin
        c.more = left > alloc;
        c.data = (alloc >= VW) ? rest : rest & ((64'd1 << alloc) - 64'd1);
        c.bits = 7'(alloc);
        owed_q.push_back(c);
        rest  = (alloc >= VW) ? '0 : rest >> alloc;
        left -= alloc;
        alloc = ext_len;
        count++;
      end while (left > 0 && count < 64);
      if (count > longest) longest = count;
      values_seen++;
      move_len(init_score, init_len, d_init, init_thr);
      move_len(ext_score, ext_len, d_ext, ext_thr);
    endfunction

    task report(string what);
      $display("%0t ns mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_chunk(logic more, logic [VW-1:0] data, logic [6:0] bits);
      chunk_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected word more=%0b data=%h bits=%0d", more, data, bits));
        return;
      end
      want = owed_q.pop_front();
      if (more !== want.more)
        report($sformatf("word %0d more_follows %0b, want %0b", chunks_seen, more, want.more));
      if (data !== want.data)
        report($sformatf("word %0d chunk_data %h, want %h", chunks_seen, data, want.data));
      if (bits !== want.bits)
        report($sformatf("word %0d chunk_bits %0d, want %0d", chunks_seen, bits, want.bits));
      chunks_seen++;
    endtask

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                             clk         = 1'b0;
  logic                             rst_n       = 1'b0;
  logic                             cfg_wr_en   = 1'b0;
  logic [avlie_pkg::CFG_IDX_W-1:0]  cfg_index   = avlie_pkg::CFG_START_INITIAL_LEN;
  logic [avlie_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic                             in_valid    = 1'b0;
  logic                             in_ready;
  logic [VW-1:0]                    in_value    = '0;
  logic                             out_valid;
  logic                             out_ready   = 1'b0;
  logic                             out_more_follows;
  logic [VW-1:0]                    out_chunk_data;
  logic [avlie_pkg::LEN_W-1:0]      out_chunk_bits;

  chunk_scoreboard sb = new();

  // Receiver behavior: 0 always ready, 1 short stalls, 2 long stalls,
  // 3 short stalls again. A request for a long hold-off overrides all modes.
  int rx_mode       = 0;
  int hold_requests = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  always #2 clk = ~clk;

  adaptive_varlen_integer_encoder #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_more_follows(out_more_follows),
    .out_chunk_data  (out_chunk_data),
    .out_chunk_bits  (out_chunk_bits)
  );

  // Both channels are sampled at the rising edge, before any of this edge's
  // nonblocking updates land. A value noted here can only produce words at
  // later edges, so noting it first keeps the expected order intact.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_value(in_value);
    if (rst_n && out_valid && out_ready)
      sb.check_chunk(out_more_follows, out_chunk_data, out_chunk_bits);
  end

  // Hang detector: any accepted word on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no word moved for %0d cycles, %0d chunks still owed",
               quiet_cycles, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output side. Ready and stall stretches alternate with random lengths, and
  // a long hold-off, when asked for, keeps ready low long enough for the
  // encoder to fill its output register and stop taking values.
  initial begin : receiver
    int run_left;
    bit rx_on;
    int served;
    run_left = 0;
    rx_on    = 1'b1;
    served   = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != served) begin
        served++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_mode == 0) begin
        out_ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          rx_on    = !rx_on;
          run_left = rx_on ? $urandom_range(1, 16) : $urandom_range(1, rx_mode == 2 ? 12 : 3);
        end
        run_left--;
        out_ready <= rx_on;
      end
    end
  end

  // All driving tasks are entered just after a rising edge and return just
  // after one, so each signal gets at most one nonblocking update per edge.

  // Offers one value and holds it until the encoder takes it.
  task automatic send_value(input logic [VW-1:0] v);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid, waits until a value taken at the previous edge has been
  // noted, waits for every owed chunk, then lets the score update of the
  // last value finish so the encoder is truly idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input avlie_pkg::cfg_idx_t idx,
                           input logic [avlie_pkg::CFG_DATA_W-1:0] d);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= d;
    sb.set_reg(idx, d);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [avlie_pkg::CFG_DATA_W-1:0] start_init,
                               input logic [avlie_pkg::CFG_DATA_W-1:0] start_ext,
                               input logic [avlie_pkg::CFG_DATA_W-1:0] thr_init,
                               input logic [avlie_pkg::CFG_DATA_W-1:0] thr_ext);
    wait_idle();
    write_reg(avlie_pkg::CFG_START_INITIAL_LEN, start_init);
    write_reg(avlie_pkg::CFG_START_EXTEND_LEN, start_ext);
    write_reg(avlie_pkg::CFG_INITIAL_THRESHOLD, thr_init);
    write_reg(avlie_pkg::CFG_EXTEND_THRESHOLD, thr_ext);
    settings_used++;
  endtask

  // Most values sit a little below or a few chunks above the current initial
  // length, so that both scores move in both directions; the rest are zero,
  // all ones, full-width noise or a length anywhere from 1 to 64.
  function automatic logic [VW-1:0] pick_value(input int typical);
    int            sel, nb;
    logic [VW-1:0] r;
    r   = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 5) return '0;
    if (sel < 8) return '1;
    if (sel < 20) return r;
    if (sel < 85) nb = typical + $urandom_range(0, 26) - 6;
    else nb = $urandom_range(1, 64);
    if (nb < 1) nb = 1;
    if (nb > 64) nb = 64;
    if (nb < 64) r &= (64'd1 << nb) - 64'd1;
    r[nb-1] = 1'b1;
    return r;
  endfunction

  function automatic logic [avlie_pkg::CFG_DATA_W-1:0] pick_start();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return avlie_pkg::CFG_DATA_W'($urandom_range(65, 1023));
    if (sel == 2) return avlie_pkg::CFG_DATA_W'($urandom_range(1, 64));
    return avlie_pkg::CFG_DATA_W'($urandom_range(1, 12));
  endfunction

  function automatic logic [avlie_pkg::CFG_DATA_W-1:0] pick_thr();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return 10'd1023;
    if (sel == 2) return avlie_pkg::CFG_DATA_W'($urandom_range(1, 1023));
    return avlie_pkg::CFG_DATA_W'($urandom_range(1, 16));
  endfunction

  // Sends values in bursts of random length; between bursts valid drops for
  // a random gap bounded by max_gap (no gaps when max_gap is zero).
  task automatic run_values(input int count, input int max_gap);
    int burst;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if (max_gap > 0 && k > 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, max_gap)) @(posedge clk);
        end
      end
      send_value(pick_value(sb.init_len));
      burst--;
    end
  endtask

  initial begin : stimulus
    int gap;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner values at the reset lengths (8 then 4): zero, exact fits,
    // one bit over with padding, and full-width patterns.
    rx_mode = 1;
    for (int k = 0; k < 12; k++) send_value(CORNERS[k]);

    // Start lengths of zero load 1: a full-width value needs 64 chunks.
    apply_setting(10'd0, 10'd0, 10'd1023, 10'd1023);
    send_value('1);
    send_value(64'h0);
    send_value(64'h3);

    // Start lengths above 64 (upper data bits set too) load 64, and zero
    // thresholds make every score cross at once; lengths saturate at 64.
    apply_setting(10'h3C1, 10'h3FF, 10'd0, 10'd0);
    send_value('1);
    send_value(64'h5);
    apply_setting(10'd1, 10'd1, 10'd0, 10'd0);
    send_value(64'h1);
    send_value(64'h1);
    send_value(64'h1);

    // Threshold of one: each length drops from 64 once its score moves.
    apply_setting(10'd64, 10'd64, 10'd1, 10'd1);
    send_value(64'h0);
    send_value('1);

    // A start length write in the middle of a run reloads the length and
    // drops the score that has built up.
    apply_setting(10'd8, 10'd4, 10'd1023, 10'd1023);
    send_value(64'h3);
    send_value(64'h7);
    wait_idle();
    write_reg(avlie_pkg::CFG_START_INITIAL_LEN, 10'd8);
    send_value(64'h1F);
    send_value(64'hF_FFFF);

    // Random phases, each with a fresh setting. The third phase runs without
    // gaps into a long receiver hold-off so the encoder backs up; every phase
    // ends with the sender paused until all chunks are home.
    for (int p = 0; p < PHASES; p++) begin
      apply_setting(pick_start(), pick_start(), pick_thr(), pick_thr());
      rx_mode = p % 4;
      gap     = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 6 : 30);
      if (p == 2) begin
        gap = 0;
        hold_requests++;
      end
      run_values(PHASE_VALUES, gap);
    end

    wait_idle();
    repeat (TAIL) @(posedge clk);

    $display("Encoded %0d values into %0d chunks under %0d register settings.",
             sb.values_seen, sb.chunks_seen, settings_used + 1);
    $display("Longest value took %0d chunks; %0d mismatches found.",
             sb.longest, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/avlie_pkg.sv
rtl/adaptive_varlen_integer_encoder.sv
verif/testbench.sv
